// ===== rtl/llsa_pkg.sv =====
// Shared types, constants and helper functions for the least-loaded slot allocator.
`default_nettype none

package llsa_pkg;

   localparam int MAX_SLOTS   = 8;
   localparam int COUNT_WIDTH = 16;
   localparam int SLOT_W      = $clog2(MAX_SLOTS);
   localparam int NUM_W       = $clog2(MAX_SLOTS + 1);
   localparam int CFG_W       = 4;
   localparam int RSLOT_W     = 4;
   localparam int CSR_IDX_W   = 2;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REAL_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLIM_TOPO  = 2'd2;

   localparam logic MODE_CLAIM   = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_PARAM = 2'd1;
   localparam logic [1:0] ST_NO_FULL   = 2'd2;
   localparam logic [1:0] ST_IGNORED   = 2'd3;

   localparam logic [1:0] KIND_VIDEO0 = 2'd0;
   localparam logic [1:0] KIND_VIDEO1 = 2'd1;
   localparam logic [1:0] KIND_ENH    = 2'd2;

   typedef struct packed {
      logic                   clear;
      logic                   take;
      logic                   elig;
      logic                   sel_elig;
      logic [SLOT_W-1:0]      slot;
      logic [COUNT_WIDTH-1:0] count;
   } pick_ctl_type;

   typedef struct packed {
      logic                   level;
      logic                   ev;
      logic [COUNT_WIDTH-1:0] em;
      logic [SLOT_W-1:0]      eb;
      logic                   fv;
      logic [COUNT_WIDTH-1:0] fm;
      logic [SLOT_W-1:0]      fb;
   } pick_res_type;

   function automatic logic [NUM_W-1:0] pool_size(input logic [CFG_W-1:0] sc);
      int v;
      v = int'(sc);
      if (v == 0) v = 1;
      if (v > MAX_SLOTS) v = MAX_SLOTS;
      return NUM_W'(v);
   endfunction

   function automatic logic [NUM_W-1:0] video_count(input logic [CFG_W-1:0] rc,
                                                    input logic [NUM_W-1:0] n);
      int v;
      v = int'(rc);
      if (v > int'(n)) v = int'(n);
      return NUM_W'(v);
   endfunction

   function automatic logic [1:0] kind_of(input logic [SLOT_W-1:0] slot,
                                          input logic [NUM_W-1:0] nv);
      logic [1:0] k;
      if (int'(slot) >= int'(nv)) k = KIND_ENH;
      else if (slot[0]) k = KIND_VIDEO1;
      else k = KIND_VIDEO0;
      return k;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/llsa_pick.sv =====
// Scan accumulator: level test and least-loaded search over streamed slot counts.
`default_nettype none

module llsa_pick
   import llsa_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire pick_ctl_type ctl,
   output pick_res_type      res
);

   logic                   seen_ff, seen_in;
   logic [COUNT_WIDTH-1:0] first_ff, first_in;
   pick_res_type           acc_ff, acc_in;

   always_comb begin
      seen_in  = seen_ff;
      first_in = first_ff;
      acc_in   = acc_ff;
      if (ctl.clear) begin
         seen_in   = 1'b0;
         acc_in.level = 1'b1;
         acc_in.ev = 1'b0;
         acc_in.fv = 1'b0;
      end else if (ctl.take) begin
         if (ctl.elig) begin
            if (!seen_ff) begin
               seen_in  = 1'b1;
               first_in = ctl.count;
            end else if (ctl.count != first_ff) begin
               acc_in.level = 1'b0;
            end
         end
         if (ctl.sel_elig) begin
            if (!acc_ff.ev || ctl.count < acc_ff.em) begin
               acc_in.ev = 1'b1;
               acc_in.em = ctl.count;
               acc_in.eb = ctl.slot;
            end
         end else if (!ctl.elig) begin
            if (!acc_ff.fv || ctl.count < acc_ff.fm) begin
               acc_in.fv = 1'b1;
               acc_in.fm = ctl.count;
               acc_in.fb = ctl.slot;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         acc_ff.level <= 1'b1;
         acc_ff.ev    <= 1'b0;
         acc_ff.fv    <= 1'b0;
      end else begin
         seen_ff      <= seen_in;
         acc_ff.level <= acc_in.level;
         acc_ff.ev    <= acc_in.ev;
         acc_ff.fv    <= acc_in.fv;
      end
      first_ff  <= first_in;
      acc_ff.em <= acc_in.em;
      acc_ff.eb <= acc_in.eb;
      acc_ff.fm <= acc_in.fm;
      acc_ff.fb <= acc_in.fb;
   end

   assign res = acc_ff;

endmodule

`default_nettype wire

// ===== rtl/least_loaded_slot_allocator.sv =====
// Top level: claim/release sequencer around the per-slot claim count memory.
// Steps per item, with n the pool size: a claim reduces its origin modulo n, scans the
// n slot counts and decides, plus a pass over the counts for a group claim, then sets the
// output register; a release makes one pass over the counts first, an ignored release none.
// One item is in work at a time; the scans over the count memory set the rate.
// Reset is synchronous: counts read as zero, origins return to zero and MAX_SLOTS-1,
// registers return to slot count 1, real count 0, slim flag 0.
`default_nettype none

module least_loaded_slot_allocator
   import llsa_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_mode,
   input  wire logic                 req_is_encode,
   input  wire logic                 req_need_full,
   input  wire logic                 req_scalable,
   input  wire logic [RSLOT_W-1:0]   req_release_slot,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [SLOT_W-1:0]         rsp_granted_slot,
   output logic [1:0]                rsp_engine_kind,
   output logic                      rsp_scalable_granted
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_MOD    = 6'b000010,
      S_SCAN   = 6'b000100,
      S_DECIDE = 6'b001000,
      S_PASS   = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [CFG_W-1:0] slot_count_ff, slot_count_in;
   logic [CFG_W-1:0] real_count_ff, real_count_in;
   logic             slim_ff, slim_in;

   logic [SLOT_W-1:0] enc_origin_ff, enc_origin_in;
   logic [SLOT_W-1:0] dec_origin_ff, dec_origin_in;

   logic               enc_ff, enc_in;
   logic               full_ff, full_in;
   logic               grp_ff, grp_in;
   logic               grp_ok_ff, grp_ok_in;
   logic [RSLOT_W-1:0] rslot_ff, rslot_in;
   logic               inc_ff, inc_in;
   logic               anynz_ff, anynz_in;

   logic [SLOT_W-1:0] start_ff, start_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [NUM_W-1:0]  cnt_ff, cnt_in;
   logic              rd_live_ff, rd_live_in;
   logic [SLOT_W-1:0] rd_slot_ff;

   logic [1:0]        res_status_ff, res_status_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic [1:0]        res_kind_ff, res_kind_in;
   logic              res_grp_ff, res_grp_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [1:0]        rsp_kind_ff, rsp_kind_in;
   logic              rsp_grp_ff, rsp_grp_in;

   logic [COUNT_WIDTH-1:0] mem [MAX_SLOTS];
   logic [MAX_SLOTS-1:0]   vld_ff;
   logic [COUNT_WIDTH-1:0] rd_raw_ff;
   logic                   rd_vld_ff;
   logic                   wr_en;
   logic [SLOT_W-1:0]      wr_addr;
   logic [COUNT_WIDTH-1:0] wr_data;
   logic [COUNT_WIDTH-1:0] count_rd;

   logic [NUM_W-1:0]       pool_n;
   logic [NUM_W-1:0]       vid_n;
   logic                   issue;
   logic [SLOT_W-1:0]      idx_next;
   logic                   rd_vid;
   logic                   rd_slim;
   logic                   rd_elig;
   logic                   pass_hit;
   logic [COUNT_WIDTH-1:0] pass_new;
   logic                   spill;
   logic [SLOT_W-1:0]      best_slot;
   logic [COUNT_WIDTH-1:0] best_count;
   logic [SLOT_W-1:0]      origin_next;

   pick_ctl_type pick_ctl;
   pick_res_type pick_res;

   llsa_pick u_pick (
      .clock (clock),
      .reset (reset),
      .ctl   (pick_ctl),
      .res   (pick_res)
   );

   assign pool_n   = pool_size(slot_count_ff);
   assign vid_n    = video_count(real_count_ff, pool_n);
   assign count_rd = rd_vld_ff ? rd_raw_ff : '0;
   assign issue    = cnt_ff < pool_n;
   assign idx_next = (NUM_W'(idx_ff) + NUM_W'(1) >= pool_n) ? '0 : idx_ff + SLOT_W'(1);

   assign rd_vid  = int'(rd_slot_ff) < int'(vid_n);
   assign rd_slim = slim_ff && rd_vid;
   assign rd_elig = !slim_ff || (full_ff ? !rd_slim : rd_slim);

   assign pass_hit = inc_ff ? rd_vid
                            : (grp_ff ? rd_vid : (int'(rd_slot_ff) == int'(rslot_ff)));
   always_comb begin
      pass_new = count_rd;
      if (pass_hit) begin
         if (inc_ff) begin
            if (count_rd != COUNT_MAX) pass_new = count_rd + COUNT_WIDTH'(1);
         end else begin
            if (count_rd != '0) pass_new = count_rd - COUNT_WIDTH'(1);
         end
      end
   end

   assign spill      = !full_ff && pick_res.ev && pick_res.fv && (pick_res.em > pick_res.fm);
   assign best_slot  = (spill || !pick_res.ev) ? pick_res.fb : pick_res.eb;
   assign best_count = (spill || !pick_res.ev) ? pick_res.fm : pick_res.em;
   assign origin_next = (NUM_W'(start_ff) + NUM_W'(1) == pool_n) ? '0
                                                                : start_ff + SLOT_W'(1);

   always_comb begin
      state_in      = state_ff;
      slot_count_in = slot_count_ff;
      real_count_in = real_count_ff;
      slim_in       = slim_ff;
      enc_origin_in = enc_origin_ff;
      dec_origin_in = dec_origin_ff;
      enc_in        = enc_ff;
      full_in       = full_ff;
      grp_in        = grp_ff;
      grp_ok_in     = grp_ok_ff;
      rslot_in      = rslot_ff;
      inc_in        = inc_ff;
      anynz_in      = anynz_ff;
      start_in      = start_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      rd_live_in    = 1'b0;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_kind_in   = res_kind_ff;
      res_grp_in    = res_grp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_grp_in    = rsp_grp_ff;
      wr_en         = 1'b0;
      wr_addr       = rd_slot_ff;
      wr_data       = pass_new;
      pick_ctl          = '0;
      pick_ctl.elig     = rd_elig;
      pick_ctl.sel_elig = grp_ok_ff ? rd_vid : rd_elig;
      pick_ctl.slot     = rd_slot_ff;
      pick_ctl.count    = count_rd;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_SLOT_COUNT: slot_count_in = csr_wdata;
            CSR_REAL_COUNT: real_count_in = csr_wdata;
            CSR_SLIM_TOPO:  slim_in       = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               enc_in    = req_is_encode;
               full_in   = slim_ff && req_need_full;
               grp_in    = req_scalable;
               grp_ok_in = req_scalable && !(slim_ff && req_need_full) &&
                           (vid_n >= NUM_W'(2));
               rslot_in  = req_release_slot;
               res_status_in = ST_OK;
               res_slot_in   = '0;
               res_kind_in   = KIND_VIDEO0;
               res_grp_in    = 1'b0;
               if (req_mode == MODE_RELEASE) begin
                  if (int'(req_release_slot) >= int'(pool_n)) begin
                     res_status_in = ST_IGNORED;
                     state_in      = S_DONE;
                  end else begin
                     inc_in   = 1'b0;
                     idx_in   = '0;
                     cnt_in   = '0;
                     anynz_in = 1'b0;
                     state_in = S_PASS;
                  end
               end else begin
                  start_in = req_is_encode ? enc_origin_ff : dec_origin_ff;
                  state_in = S_MOD;
               end
            end
         end
         S_MOD: begin
            if (NUM_W'(start_ff) >= pool_n) begin
               start_in = SLOT_W'(NUM_W'(start_ff) - pool_n);
            end else begin
               idx_in         = start_ff;
               cnt_in         = '0;
               pick_ctl.clear = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            pick_ctl.take = rd_live_ff;
            if (issue) begin
               rd_live_in = 1'b1;
               idx_in     = idx_next;
               cnt_in     = cnt_ff + NUM_W'(1);
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (pick_res.level) begin
               if (enc_ff) enc_origin_in = origin_next;
               else dec_origin_in = origin_next;
            end
            if (grp_ok_ff) begin
               res_slot_in = pick_res.eb;
               res_kind_in = kind_of(pick_res.eb, vid_n);
               res_grp_in  = 1'b1;
               inc_in      = 1'b1;
               idx_in      = '0;
               cnt_in      = '0;
               anynz_in    = 1'b0;
               state_in    = S_PASS;
            end else if (full_ff && !pick_res.ev) begin
               res_status_in = ST_NO_FULL;
               state_in      = S_DONE;
            end else begin
               wr_en   = 1'b1;
               wr_addr = best_slot;
               wr_data = (best_count == COUNT_MAX) ? best_count
                                                   : best_count + COUNT_WIDTH'(1);
               res_slot_in = best_slot;
               res_kind_in = kind_of(best_slot, vid_n);
               state_in    = S_DONE;
            end
         end
         S_PASS: begin
            if (rd_live_ff) begin
               wr_en    = 1'b1;
               anynz_in = anynz_ff || (pass_new != '0);
            end
            if (issue) begin
               rd_live_in = 1'b1;
               idx_in     = idx_next;
               cnt_in     = cnt_ff + NUM_W'(1);
            end else begin
               if (!inc_ff && !anynz_in) begin
                  enc_origin_in = '0;
                  dec_origin_in = SLOT_W'(MAX_SLOTS - 1);
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_kind_in   = res_kind_ff;
               rsp_grp_in    = res_grp_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slot_count_ff <= CFG_W'(1);
         real_count_ff <= '0;
         slim_ff       <= 1'b0;
         enc_origin_ff <= '0;
         dec_origin_ff <= SLOT_W'(MAX_SLOTS - 1);
         rd_live_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_count_ff <= slot_count_in;
         real_count_ff <= real_count_in;
         slim_ff       <= slim_in;
         enc_origin_ff <= enc_origin_in;
         dec_origin_ff <= dec_origin_in;
         rd_live_ff    <= rd_live_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      enc_ff        <= enc_in;
      full_ff       <= full_in;
      grp_ff        <= grp_in;
      grp_ok_ff     <= grp_ok_in;
      rslot_ff      <= rslot_in;
      inc_ff        <= inc_in;
      anynz_ff      <= anynz_in;
      start_ff      <= start_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      rd_slot_ff    <= idx_ff;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_kind_ff   <= res_kind_in;
      res_grp_ff    <= res_grp_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_grp_ff    <= rsp_grp_in;
   end

   // count store: entries read as zero until first written after reset
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_raw_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) vld_ff[wr_addr] <= 1'b1;
         rd_vld_ff <= vld_ff[idx_ff];
      end
   end

   assign req_stall            = (state_ff != S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_granted_slot     = rsp_slot_ff;
   assign rsp_engine_kind      = rsp_kind_ff;
   assign rsp_scalable_granted = rsp_grp_ff;

`ifndef SYNTH
   a_wr_state : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_DECIDE || state_ff == S_PASS))
      else $error("count write outside decide or pass");

   a_no_rw_clash : assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_live_in) |-> (wr_addr != idx_ff))
      else $error("read and write of the same count entry in one cycle");

   a_scan_idx : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_PASS) |-> (NUM_W'(idx_ff) < pool_n))
      else $error("scan index beyond pool");

   a_rsp_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside done state");
`endif

endmodule

`default_nettype wire
